/* rtl/pff_pkg.sv */
// ----------------------------------------------------------------------------
// pff_pkg: shared types and constants of the pipe friction factor unit
// Fixed-point widths and constants of the laminar, transition and
// Colebrook-White paths.
// ----------------------------------------------------------------------------
package pff_pkg;

    localparam int DEF_ITERATIONS = 5;

    localparam int FF_W      = 32;
    localparam int RR_W      = 24;
    localparam int RE_W      = 24;
    localparam int R_W       = 31;

    localparam int LAM_NUM_W = 31;
    localparam int SQ_V_W    = 56;
    localparam int SQ_Q_W    = 28;
    localparam int T_NUM_W   = 58;
    localparam int T_DEN_W   = 52;
    localparam int Y_W       = 64;
    localparam int LZ_W      = 6;
    localparam int LOG_M_W   = 31;
    localparam int LOG_F_W   = 24;
    localparam int ABSL_W    = 30;
    localparam int XQ_W      = 28;
    localparam int U_NUM_W   = 47;
    localparam int RES_NUM_W = 51;

    localparam logic [FF_W-1:0]      FF_MAX   = 32'hFFFF_FFFF;
    localparam logic [FF_W-1:0]      FF_START = 32'd33554;
    localparam logic [RE_W-1:0]      RE_LAM   = 24'd700;
    localparam logic [RE_W-1:0]      RE_TURB  = 24'd3000;
    localparam logic [RE_W-1:0]      TRANS_K  = 24'd11083077;
    localparam logic [LAM_NUM_W-1:0] LAM_NUM  = 31'h4000_0000;
    localparam logic [T_NUM_W-1:0]   C252     = 58'd181585136975578399;
    localparam logic [R_W-1:0]       C027     = 31'd1159641170;
    localparam logic [30:0]          LOG10_2  = 31'd1292913986;
    localparam logic [XQ_W-1:0]      XQ_SAT   = 28'd524288;
    localparam logic [U_NUM_W-1:0]   U_NUM    = 47'h4000_0000_0000;

    typedef enum logic [1:0] {
        SEL_SAT    = 2'd0,
        SEL_DIRECT = 2'd1,
        SEL_TURB   = 2'd2
    } sel_t;

    typedef struct packed {
        logic [RE_W-1:0] re;
        logic [R_W-1:0]  r;
        sel_t            sel;
        logic [FF_W-1:0] lam;
    } side_t;

endpackage

/* rtl/pff_div_cell.sv */
// ----------------------------------------------------------------------------
// pff_div_cell: one restoring division step
// Shifts the next numerator bit into the remainder and produces one
// quotient bit; divisor and side data travel along.
// ----------------------------------------------------------------------------
module pff_div_cell #(
    parameter int NW = 31,
    parameter int RW = 24,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [NW-1:0] in_quo,
    input  logic [RW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [RW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [NW-1:0] out_quo,
    output logic [RW-1:0] out_den,
    output logic [SW-1:0] out_side
);

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic          valid_reg;
    logic [RW-1:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [RW-1:0] den_reg;
    logic [SW-1:0] side_reg;

    assign trial    = {in_rem, in_num[NW-1]};
    assign diff     = trial - {1'b0, in_den};
    assign ge       = (trial >= {1'b0, in_den});
    assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {in_num[NW-2:0], 1'b0};
            quo_reg  <= {in_quo[NW-2:0], ge};
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/pff_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// pff_sqrt_cell: one digit step of an integer square root
// Takes two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
module pff_sqrt_cell #(
    parameter int VW = 56,
    parameter int QW = 28,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [QW:0]   in_rem,
    input  logic [QW-1:0] in_root,
    input  logic [VW-1:0] in_val,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW:0]   out_rem,
    output logic [QW-1:0] out_root,
    output logic [VW-1:0] out_val,
    output logic [SW-1:0] out_side
);

    logic [QW+2:0] rem4;
    logic [QW+2:0] trial;
    logic [QW+2:0] diff;
    logic          ge;
    logic          valid_reg;
    logic [QW:0]   rem_reg;
    logic [QW-1:0] root_reg;
    logic [VW-1:0] val_reg;
    logic [SW-1:0] side_reg;

    assign rem4  = {in_rem, in_val[VW-1:VW-2]};
    assign trial = {1'b0, in_root, 2'b01};
    assign diff  = rem4 - trial;
    assign ge    = (rem4 >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg  <= ge ? diff[QW:0] : rem4[QW:0];
            root_reg <= {in_root[QW-2:0], ge};
            val_reg  <= {in_val[VW-3:0], 2'b00};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_val   = val_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/pff_log_cell.sv */
// ----------------------------------------------------------------------------
// pff_log_cell: one fraction bit of a base-2 logarithm
// Squares the Q1.30 mantissa and renormalizes it to [1, 2).
// ----------------------------------------------------------------------------
module pff_log_cell #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [30:0]   in_mant,
    input  logic [23:0]   in_frac,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [30:0]   out_mant,
    output logic [23:0]   out_frac,
    output logic [SW-1:0] out_side
);

    logic [61:0]   sq;
    logic [31:0]   m2;
    logic          valid_reg;
    logic [30:0]   mant_reg;
    logic [23:0]   frac_reg;
    logic [SW-1:0] side_reg;

    assign sq = 62'(in_mant) * 62'(in_mant);
    assign m2 = sq[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mant_reg <= m2[31] ? m2[31:1] : m2[30:0];
            frac_reg <= {in_frac[22:0], m2[31]};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_mant  = mant_reg;
    assign out_frac  = frac_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/pff_iter.sv */
// ----------------------------------------------------------------------------
// pff_iter: one Colebrook-White iteration
// Square root, divider, leading-one normalizer, logarithm and two
// dividers, all as chains of registered cells; 219 stages.
// ----------------------------------------------------------------------------
module pff_iter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic [31:0]             in_ff,
    input  pff_pkg::side_t          in_side,
    output logic                    out_valid,
    output logic [31:0]             out_ff,
    output pff_pkg::side_t          out_side
);

    import pff_pkg::*;

    localparam int SW     = $bits(side_t);
    localparam int NSTEPS = $clog2(Y_W);

    // Square root of ff in Q.24.
    logic                sq_v    [0:SQ_Q_W];
    logic [SQ_Q_W:0]     sq_rem  [0:SQ_Q_W];
    logic [SQ_Q_W-1:0]   sq_root [0:SQ_Q_W];
    logic [SQ_V_W-1:0]   sq_val  [0:SQ_Q_W];
    logic [SW-1:0]       sq_side [0:SQ_Q_W];

    assign sq_v[0]    = in_valid;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_val[0]  = {in_ff, {(SQ_V_W-FF_W){1'b0}}};
    assign sq_side[0] = in_side;

    for (genvar g = 0; g < SQ_Q_W; g++)
    begin : g_sqrt
        pff_sqrt_cell #(.VW(SQ_V_W), .QW(SQ_Q_W), .SW(SW)) u_cell (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(sq_v[g]), .in_rem(sq_rem[g]), .in_root(sq_root[g]),
            .in_val(sq_val[g]), .in_side(sq_side[g]),
            .out_valid(sq_v[g+1]), .out_rem(sq_rem[g+1]), .out_root(sq_root[g+1]),
            .out_val(sq_val[g+1]), .out_side(sq_side[g+1])
        );
    end

    // Divisor Re * sqrt(ff).
    side_t               sq_sd;
    logic [SQ_Q_W-1:0]   s_fix;
    logic [T_DEN_W-1:0]  d_next;
    logic                m_valid_reg;
    logic [T_DEN_W-1:0]  d_reg;
    side_t               m_side_reg;

    assign sq_sd  = side_t'(sq_side[SQ_Q_W]);
    assign s_fix  = (sq_root[SQ_Q_W] == '0) ? SQ_Q_W'(1) : sq_root[SQ_Q_W];
    assign d_next = T_DEN_W'(sq_sd.re) * T_DEN_W'(s_fix);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            m_valid_reg <= sq_v[SQ_Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_reg      <= d_next;
            m_side_reg <= sq_sd;
        end
    end

    // t = 2.52 / (Re * s) in Q.32.
    logic                t_v    [0:T_NUM_W];
    logic [T_DEN_W-1:0]  t_rem  [0:T_NUM_W];
    logic [T_NUM_W-1:0]  t_num  [0:T_NUM_W];
    logic [T_NUM_W-1:0]  t_quo  [0:T_NUM_W];
    logic [T_DEN_W-1:0]  t_den  [0:T_NUM_W];
    logic [SW-1:0]       t_side [0:T_NUM_W];

    assign t_v[0]    = m_valid_reg;
    assign t_rem[0]  = '0;
    assign t_num[0]  = C252;
    assign t_quo[0]  = '0;
    assign t_den[0]  = d_reg;
    assign t_side[0] = m_side_reg;

    for (genvar g = 0; g < T_NUM_W; g++)
    begin : g_tdiv
        pff_div_cell #(.NW(T_NUM_W), .RW(T_DEN_W), .SW(SW)) u_cell (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(t_v[g]), .in_rem(t_rem[g]), .in_num(t_num[g]),
            .in_quo(t_quo[g]), .in_den(t_den[g]), .in_side(t_side[g]),
            .out_valid(t_v[g+1]), .out_rem(t_rem[g+1]), .out_num(t_num[g+1]),
            .out_quo(t_quo[g+1]), .out_den(t_den[g+1]), .out_side(t_side[g+1])
        );
    end

    // Logarithm argument y = 0.27*rr + t, at least one LSB.
    side_t               t_sd;
    logic [Y_W-1:0]      y_sum;
    logic                y_valid_reg;
    logic [Y_W-1:0]      y_reg;
    side_t               y_side_reg;

    assign t_sd  = side_t'(t_side[T_NUM_W]);
    assign y_sum = Y_W'(t_quo[T_NUM_W]) + Y_W'(t_sd.r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            y_valid_reg <= t_v[T_NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            y_reg      <= (y_sum == '0) ? Y_W'(1) : y_sum;
            y_side_reg <= t_sd;
        end
    end

    // Leading-one normalizer, one binary shift step per stage.
    logic                n_v    [0:NSTEPS];
    logic [Y_W-1:0]      n_val  [0:NSTEPS];
    logic [LZ_W-1:0]     n_lz   [0:NSTEPS];
    side_t               n_side [0:NSTEPS];

    assign n_v[0]    = y_valid_reg;
    assign n_val[0]  = y_reg;
    assign n_lz[0]   = '0;
    assign n_side[0] = y_side_reg;

    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_norm
        localparam int SH = (Y_W / 2) >> k;

        logic            v_reg;
        logic [Y_W-1:0]  val_reg;
        logic [LZ_W-1:0] lz_reg;
        side_t           side_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (ce)
            begin
                v_reg <= n_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (n_val[k][Y_W-1 -: SH] == '0)
                begin
                    val_reg <= n_val[k] << SH;
                    lz_reg  <= n_lz[k] + LZ_W'(SH);
                end
                else
                begin
                    val_reg <= n_val[k];
                    lz_reg  <= n_lz[k];
                end
                side_reg <= n_side[k];
            end
        end

        assign n_v[k+1]    = v_reg;
        assign n_val[k+1]  = val_reg;
        assign n_lz[k+1]   = lz_reg;
        assign n_side[k+1] = side_reg;
    end

    // Fraction bits of log2 by repeated squaring.
    logic                l_v    [0:LOG_F_W];
    logic [LOG_M_W-1:0]  l_mant [0:LOG_F_W];
    logic [LOG_F_W-1:0]  l_frac [0:LOG_F_W];
    logic [SW+LZ_W-1:0]  l_side [0:LOG_F_W];

    assign l_v[0]    = n_v[NSTEPS];
    assign l_mant[0] = n_val[NSTEPS][Y_W-1 -: LOG_M_W];
    assign l_frac[0] = '0;
    assign l_side[0] = {n_lz[NSTEPS], n_side[NSTEPS]};

    for (genvar g = 0; g < LOG_F_W; g++)
    begin : g_log
        pff_log_cell #(.SW(SW+LZ_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(l_v[g]), .in_mant(l_mant[g]), .in_frac(l_frac[g]),
            .in_side(l_side[g]),
            .out_valid(l_v[g+1]), .out_mant(l_mant[g+1]), .out_frac(l_frac[g+1]),
            .out_side(l_side[g+1])
        );
    end

    // |log2(y)| in Q.24; the integer part is (63 - lz) - 32.
    logic [LZ_W-1:0]     lz;
    logic [LZ_W-1:0]     ip_pos;
    logic [LZ_W-1:0]     ip_neg;
    logic [ABSL_W-1:0]   abs_next;
    logic                a_valid_reg;
    logic [ABSL_W-1:0]   a_abs_reg;
    side_t               a_side_reg;

    assign lz       = l_side[LOG_F_W][SW+LZ_W-1:SW];
    assign ip_pos   = 6'd31 - lz;
    assign ip_neg   = lz - 6'd31;
    assign abs_next = (lz <= 6'd31) ? {1'b0, ip_pos[4:0], l_frac[LOG_F_W]}
                                    : ({ip_neg, 24'b0} - {6'b0, l_frac[LOG_F_W]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= l_v[LOG_F_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_abs_reg  <= abs_next;
            a_side_reg <= side_t'(l_side[LOG_F_W][SW-1:0]);
        end
    end

    // |log10(y)| in Q.24 and the near-zero check.
    logic [60:0]         x_prod;
    logic [XQ_W-1:0]     xq_next;
    logic                x_valid_reg;
    logic [XQ_W-1:0]     x_xq_reg;
    logic                x_sat_reg;
    side_t               x_side_reg;

    assign x_prod  = 61'(a_abs_reg) * 61'(LOG10_2);
    assign xq_next = x_prod[59:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            x_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_xq_reg   <= xq_next;
            x_sat_reg  <= (xq_next <= XQ_SAT);
            x_side_reg <= a_side_reg;
        end
    end

    // u = 2^46 / xq.
    logic                u_v    [0:U_NUM_W];
    logic [XQ_W-1:0]     u_rem  [0:U_NUM_W];
    logic [U_NUM_W-1:0]  u_num  [0:U_NUM_W];
    logic [U_NUM_W-1:0]  u_quo  [0:U_NUM_W];
    logic [XQ_W-1:0]     u_den  [0:U_NUM_W];
    logic [SW:0]         u_side [0:U_NUM_W];

    assign u_v[0]    = x_valid_reg;
    assign u_rem[0]  = '0;
    assign u_num[0]  = U_NUM;
    assign u_quo[0]  = '0;
    assign u_den[0]  = x_xq_reg;
    assign u_side[0] = {x_sat_reg, x_side_reg};

    for (genvar g = 0; g < U_NUM_W; g++)
    begin : g_udiv
        pff_div_cell #(.NW(U_NUM_W), .RW(XQ_W), .SW(SW+1)) u_cell (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(u_v[g]), .in_rem(u_rem[g]), .in_num(u_num[g]),
            .in_quo(u_quo[g]), .in_den(u_den[g]), .in_side(u_side[g]),
            .out_valid(u_v[g+1]), .out_rem(u_rem[g+1]), .out_num(u_num[g+1]),
            .out_quo(u_quo[g+1]), .out_den(u_den[g+1]), .out_side(u_side[g+1])
        );
    end

    // ff = (u * 2^24) / xq.
    logic                  r_v    [0:RES_NUM_W];
    logic [XQ_W-1:0]       r_rem  [0:RES_NUM_W];
    logic [RES_NUM_W-1:0]  r_num  [0:RES_NUM_W];
    logic [RES_NUM_W-1:0]  r_quo  [0:RES_NUM_W];
    logic [XQ_W-1:0]       r_den  [0:RES_NUM_W];
    logic [SW:0]           r_side [0:RES_NUM_W];

    assign r_v[0]    = u_v[U_NUM_W];
    assign r_rem[0]  = '0;
    assign r_num[0]  = {u_quo[U_NUM_W][RES_NUM_W-25:0], 24'b0};
    assign r_quo[0]  = '0;
    assign r_den[0]  = u_den[U_NUM_W];
    assign r_side[0] = u_side[U_NUM_W];

    for (genvar g = 0; g < RES_NUM_W; g++)
    begin : g_rdiv
        pff_div_cell #(.NW(RES_NUM_W), .RW(XQ_W), .SW(SW+1)) u_cell (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(r_v[g]), .in_rem(r_rem[g]), .in_num(r_num[g]),
            .in_quo(r_quo[g]), .in_den(r_den[g]), .in_side(r_side[g]),
            .out_valid(r_v[g+1]), .out_rem(r_rem[g+1]), .out_num(r_num[g+1]),
            .out_quo(r_quo[g+1]), .out_den(r_den[g+1]), .out_side(r_side[g+1])
        );
    end

    // Clamp to the Q8.24 range.
    logic                  c_sat;
    logic                  c_valid_reg;
    logic [FF_W-1:0]       c_ff_reg;
    side_t                 c_side_reg;

    assign c_sat = r_side[RES_NUM_W][SW]
                   || (r_quo[RES_NUM_W] > RES_NUM_W'(FF_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            c_valid_reg <= r_v[RES_NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c_ff_reg   <= c_sat ? FF_MAX : r_quo[RES_NUM_W][FF_W-1:0];
            c_side_reg <= side_t'(r_side[RES_NUM_W][SW-1:0]);
        end
    end

    assign out_valid = c_valid_reg;
    assign out_ff    = c_ff_reg;
    assign out_side  = c_side_reg;

endmodule

/* rtl/pipe_friction_factor_unit.sv */
// Throughput: one word per cycle while the output buffer has room.
// Every step of every iteration is its own stage.
// The pipeline advances as a whole while the two-word output buffer has room.
// Reset (rst_n, asynchronous, active low) clears all valid bits and the buffer.
// ----------------------------------------------------------------------------
// pipe_friction_factor_unit: Darcy friction factor pipeline
// Laminar and transition formulas up front, then a chain of Colebrook-White
// iteration blocks, a final select and an output buffer.
// ----------------------------------------------------------------------------
module pipe_friction_factor_unit #(
    parameter int ITERATIONS = pff_pkg::DEF_ITERATIONS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] rel_roughness, [47:24] reynolds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] friction
);

    import pff_pkg::*;

    localparam int FSW = RR_W + RE_W;

    logic ce;

    // Laminar quotient 2^30 / Re.
    logic                  f_v    [0:LAM_NUM_W];
    logic [RE_W-1:0]       f_rem  [0:LAM_NUM_W];
    logic [LAM_NUM_W-1:0]  f_num  [0:LAM_NUM_W];
    logic [LAM_NUM_W-1:0]  f_quo  [0:LAM_NUM_W];
    logic [RE_W-1:0]       f_den  [0:LAM_NUM_W];
    logic [FSW-1:0]        f_side [0:LAM_NUM_W];

    assign f_v[0]    = s_tvalid;
    assign f_rem[0]  = '0;
    assign f_num[0]  = LAM_NUM;
    assign f_quo[0]  = '0;
    assign f_den[0]  = s_tdata[47:24];
    assign f_side[0] = s_tdata;

    for (genvar g = 0; g < LAM_NUM_W; g++)
    begin : g_lam
        pff_div_cell #(.NW(LAM_NUM_W), .RW(RE_W), .SW(FSW)) u_cell (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(f_v[g]), .in_rem(f_rem[g]), .in_num(f_num[g]),
            .in_quo(f_quo[g]), .in_den(f_den[g]), .in_side(f_side[g]),
            .out_valid(f_v[g+1]), .out_rem(f_rem[g+1]), .out_num(f_num[g+1]),
            .out_quo(f_quo[g+1]), .out_den(f_den[g+1]), .out_side(f_side[g+1])
        );
    end

    // Transition term, roughness term and regime select.
    logic [RE_W-1:0]   fr_re;
    logic [RR_W-1:0]   fr_rr;
    logic [47:0]       trans_prod;
    logic [54:0]       rough_prod;
    logic [FF_W-1:0]   lam_q;
    side_t             side_next;
    logic              e_valid_reg;
    side_t             e_side_reg;

    assign fr_re      = f_side[LAM_NUM_W][FSW-1:RR_W];
    assign fr_rr      = f_side[LAM_NUM_W][RR_W-1:0];
    assign trans_prod = 48'(fr_re - RE_LAM) * 48'(TRANS_K);
    assign rough_prod = 55'(fr_rr) * 55'(C027);
    assign lam_q      = FF_W'(f_quo[LAM_NUM_W]);

    always_comb
    begin
        side_next.re  = fr_re;
        side_next.r   = rough_prod[54:24];
        side_next.lam = (fr_re < RE_LAM) ? lam_q : (lam_q + trans_prod[47:16]);
        if (fr_re == '0)
        begin
            side_next.sel = SEL_SAT;
        end
        else if (fr_re < RE_TURB)
        begin
            side_next.sel = SEL_DIRECT;
        end
        else
        begin
            side_next.sel = SEL_TURB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            e_valid_reg <= f_v[LAM_NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e_side_reg <= side_next;
        end
    end

    // Colebrook-White iterations; non-turbulent words ride along unused.
    logic              it_v    [0:ITERATIONS];
    logic [FF_W-1:0]   it_ff   [0:ITERATIONS];
    side_t             it_side [0:ITERATIONS];

    assign it_v[0]    = e_valid_reg;
    assign it_ff[0]   = FF_START;
    assign it_side[0] = e_side_reg;

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_iter
        pff_iter u_iter (
            .clk(clk), .rst_n(rst_n), .ce(ce),
            .in_valid(it_v[g]), .in_ff(it_ff[g]), .in_side(it_side[g]),
            .out_valid(it_v[g+1]), .out_ff(it_ff[g+1]), .out_side(it_side[g+1])
        );
    end

    // Final select.
    logic              fin_valid_reg;
    logic [FF_W-1:0]   fin_ff_reg;
    logic [FF_W-1:0]   fin_ff_next;
    side_t             last_side;

    assign last_side = it_side[ITERATIONS];

    always_comb
    begin
        case (last_side.sel)
            SEL_SAT:    fin_ff_next = FF_MAX;
            SEL_DIRECT: fin_ff_next = last_side.lam;
            SEL_TURB:   fin_ff_next = it_ff[ITERATIONS];
            default:    fin_ff_next = FF_MAX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            fin_valid_reg <= it_v[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fin_ff_reg <= fin_ff_next;
        end
    end

    // Two-word output buffer; the pipeline stops only when it is full.
    logic [FF_W-1:0]   buf_reg [0:1];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              pop;

    assign ce       = (cnt_reg != 2'd2);
    assign s_tready = ce;
    assign push     = ce && fin_valid_reg;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= fin_ff_reg;
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !m_tready) |=> (cnt_reg == 2'd2))
        else $error("full output buffer lost a word");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !ce) |=> (fin_valid_reg && $stable(fin_ff_reg)))
        else $error("stalled final word was dropped or changed");
`endif

endmodule

/* tb/sv/tb_pipe_friction_factor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pipe_friction_factor_unit: stream test of the friction factor pipeline
// Drives roughness/Reynolds words with random gaps and output stalls, predicts
// each friction factor in integer arithmetic and checks results in order.
// ----------------------------------------------------------------------------
module tb_pipe_friction_factor_unit;
    import pff_pkg::*;

    localparam int N_RANDOM   = 1380;
    localparam int LATENCY    = 34 + 219 * DEF_ITERATIONS;
    localparam int HOLD_LEN   = 3000;

    class friction_board;
        logic [31:0] pending_ff[$];
        int          errors;
        int          checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function automatic longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic longint unsigned abs_log2(longint unsigned y);
            int              p;
            longint unsigned m;
            longint          l2;
            p = 63;
            while (p > 0 && y[p] == 1'b0)
                p--;
            if (p >= 30)
                m = y >> (p - 30);
            else
                m = y << (30 - p);
            l2 = longint'(p - 32) * 64'sd16777216;
            for (int i = 23; i >= 0; i--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    l2 = l2 + (64'sd1 <<< i);
                end
            end
            return (l2 < 0) ? longint'(-l2) : longint'(l2);
        endfunction

        function automatic longint unsigned colebrook(longint unsigned ff,
                                                      longint unsigned rr,
                                                      longint unsigned re);
            longint unsigned s, t, r, y, xq, u, res;
            s = root64(ff << 24);
            if (s == 0)
                s = 1;
            t = 64'd181585136975578399 / (re * s);
            r = (rr * 64'd1159641170) >> 24;
            y = r + t;
            if (y == 0)
                y = 1;
            xq = (abs_log2(y) * 64'd1292913986) >> 32;
            if (xq <= (64'd1 << 19))
                return 64'hFFFF_FFFF;
            u   = (64'd1 << 46) / xq;
            res = (u << 24) / xq;
            return (res > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : res;
        endfunction

        function automatic logic [31:0] friction_of(logic [23:0] rr, logic [23:0] re);
            longint unsigned ff;
            if (re == 0)
                ff = 64'hFFFF_FFFF;
            else if (re < 700)
                ff = (64'd1 << 30) / re;
            else if (re < 3000)
                ff = (64'd1 << 30) / re + ((64'd11083077 * (re - 700)) >> 16);
            else
            begin
                ff = 33554;
                for (int i = 0; i < DEF_ITERATIONS; i++)
                    ff = colebrook(ff, rr, re);
            end
            if (ff > 64'hFFFF_FFFF)
                ff = 64'hFFFF_FFFF;
            return ff[31:0];
        endfunction

        function void note_input(logic [23:0] rr, logic [23:0] re);
            pending_ff.push_back(friction_of(rr, re));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_ff.size() == 0)
                report("unexpected word", got, 32'h0);
            else
            begin
                want = pending_ff.pop_front();
                checked++;
                if (got !== want)
                    report("friction", got, want);
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [23:0] rel_roughness, [47:24] reynolds
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] friction

    friction_board board;
    bit            hold_request;
    int            sent;

    pipe_friction_factor_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Sends one word; valid stays high when the next word follows back to back.
    task send_word(logic [23:0] rr, logic [23:0] re);
        int gap;
        gap = gap_len();
        if (gap > 0 && s_tvalid)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {re, rr};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(rr, re);
        sent++;
    endtask

    task send_random();
        logic [23:0] rr;
        logic [23:0] re;
        int          k;
        rr = 24'($urandom());
        k  = $urandom_range(0, 9);
        case (k)
            0:       re = 24'($urandom_range(1, 699));
            1:       re = 24'($urandom_range(700, 2999));
            2, 3:    re = 24'($urandom());
            4:       re = 24'($urandom_range(0, 3));
            default: re = 24'($urandom_range(3000, 200000));
        endcase
        if ($urandom_range(0, 9) == 0)
            rr = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
        send_word(rr, re);
    endtask

    initial
    begin
        board        = new();
        hold_request = 0;
        sent         = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and every region boundary.
        send_word(24'h000000, 24'd0);
        send_word(24'hFFFFFF, 24'd0);
        send_word(24'h000000, 24'd1);
        send_word(24'h123456, 24'd2);
        send_word(24'h000000, 24'd699);
        send_word(24'h000000, 24'd700);
        send_word(24'hFFFFFF, 24'd701);
        send_word(24'h000000, 24'd2999);
        send_word(24'h000000, 24'd3000);
        send_word(24'hFFFFFF, 24'd3000);
        send_word(24'h000001, 24'd3001);
        send_word(24'h000000, 24'hFFFFFF);
        send_word(24'hFFFFFF, 24'hFFFFFF);
        send_word(24'h800000, 24'h800000);
        send_word(24'h000A00, 24'd100000);
        send_word(24'h00003F, 24'd4000000);
        send_word(24'h555555, 24'hAAAAAA);
        send_word(24'hAAAAAA, 24'h555555);
        send_word(24'h7FFFFF, 24'd12345);
        send_word(24'h400000, 24'd50000);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300)
                hold_request = 1;
            if (i == 800)
            begin
                // Let the pipeline drain completely before going on.
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (board.pending_ff.size() != 0)
                    @(posedge clk);
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        while (board.pending_ff.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 100) @(posedge clk);

        $display("Sent %0d words over laminar, transition and turbulent ranges,", sent);
        $display("checked %0d results under random gaps and a long output stall.",
                 board.checked);
        if (board.errors == 0 && board.pending_ff.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Output side: checks accepted words and stalls at random.
    initial
    begin
        int hold_left;
        int r;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (hold_request)
            begin
                hold_request = 0;
                hold_left    = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_tready <= 1'b1;
                else if (r < 97)
                    m_tready <= 1'b0;
                else
                begin
                    hold_left = $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #(3000000 * 12);
        $display("Timeout with %0d results outstanding", board.pending_ff.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/pff_pkg.sv
rtl/pff_div_cell.sv
rtl/pff_sqrt_cell.sv
rtl/pff_log_cell.sv
rtl/pff_iter.sv
rtl/pipe_friction_factor_unit.sv
tb/sv/tb_pipe_friction_factor_unit.sv
